/* rtl/core/sorted_multiset_predecessor_take_unit_assert.svh */
// Assertion macros shared by the RTL of the sorted multiset block.
// Each check samples on the rising edge of clk and is disabled in reset.
`ifndef SORTED_MULTISET_PREDECESSOR_TAKE_UNIT_ASSERT_SVH
`define SORTED_MULTISET_PREDECESSOR_TAKE_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define SMPT_CHECK(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("sorted multiset check failed");
`define SMPT_NEVER(lbl, expr) \
	`SMPT_CHECK(lbl, !(expr))
`else
`define SMPT_CHECK(lbl, prop)
`define SMPT_NEVER(lbl, expr)
`endif

`endif

/* rtl/core/smpt_pkg.sv */
`default_nettype none
package smpt_pkg;

	localparam int CAPACITY = 256;
	localparam int VAL_W    = 32;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_TAKE   = 1'b1;

	localparam logic [1:0] ST_INSERTED = 2'd0;
	localparam logic [1:0] ST_TAKEN    = 2'd1;
	localparam logic [1:0] ST_NONE     = 2'd2;
	localparam logic [1:0] ST_FULL     = 2'd3;

	typedef struct packed {
		logic             op;
		logic [VAL_W-1:0] value;
	} cmd_t;

	typedef struct packed {
		logic [1:0]       status;
		logic [VAL_W-1:0] taken_value;
	} rsp_t;

	// Broadcast from the controller to every cell for one operation.
	typedef struct packed {
		logic             insert_en;
		logic             take_en;
		logic [VAL_W-1:0] value;
	} cell_ctrl_t;

endpackage
`default_nettype wire

/* rtl/core/smpt_chan_if.sv */
`default_nettype none
interface smpt_chan_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* rtl/core/smpt_cell.sv */
`default_nettype none
module smpt_cell (
	input  wire logic                          clk,
	input  wire smpt_pkg::cell_ctrl_t          ctrl,
	input  wire logic                          occ,
	input  wire logic                          at_count,
	input  wire logic [smpt_pkg::VAL_W-1:0]    lo_data,
	input  wire logic                          lo_gt,
	input  wire logic [smpt_pkg::VAL_W-1:0]    up_data,
	input  wire logic                          up_le,
	output logic      [smpt_pkg::VAL_W-1:0]    data,
	output logic                               gt,
	output logic                               le,
	output logic      [smpt_pkg::VAL_W-1:0]    take_part
);

	logic [smpt_pkg::VAL_W-1:0] data_q;

	assign data = data_q;
	assign gt   = occ && (data_q > ctrl.value);
	assign le   = occ && !gt;

	// The last cell at or below the limit is the one removed on a take.
	assign take_part = (le && !up_le) ? data_q : '0;

	always_ff @(posedge clk) begin
		if (ctrl.insert_en && (gt || at_count)) begin
			// Open a slot: cells above the insert point move up by one.
			data_q <= lo_gt ? lo_data : ctrl.value;
		end else if (ctrl.take_en && !up_le) begin
			// Close the gap: cells from the removed one up move down by one.
			data_q <= up_data;
		end
	end

endmodule
`default_nettype wire

/* rtl/core/sorted_multiset_predecessor_take_unit.sv */
// Sorted multiset with predecessor take.
//
// cmd (sink) carries beats of {op, value}: op 0 inserts value, op 1 takes the
// largest held value not above value. rsp (source) returns one beat per
// command: {status, taken_value}, status 0 inserted, 1 taken, 2 nothing at or
// below the limit, 3 store full (insert dropped); taken_value is zero unless
// status is 1. Duplicates are kept; a take removes one copy.
//
// The values live in a chain of CAPACITY cells kept in ascending order. Every
// cell compares itself with the command value at once and loads from its
// lower or upper neighbor, so an item is handled by latching the beat, then
// updating the chain and loading the response register. A new command is
// taken only once the latched one has executed, and rsp must keep up for that.
//
// Reset empties the store (the count goes to zero; cell contents are left
// as they are). When rsp stalls, the finished response waits in its register
// and the next command, once latched, waits until that slot frees up.
`default_nettype none
module sorted_multiset_predecessor_take_unit #(
	parameter int CAPACITY = smpt_pkg::CAPACITY
) (
	input wire logic clk,
	input wire logic arst_n,
	smpt_chan_if.sink   cmd,
	smpt_chan_if.source rsp
);

`include "sorted_multiset_predecessor_take_unit_assert.svh"

	localparam int CW = $clog2(CAPACITY + 1);

	logic                       busy_q;
	logic                       op_s1;
	logic [smpt_pkg::VAL_W-1:0] value_s1;
	logic [CW-1:0]              count_q;
	logic                       rsp_valid_q;
	smpt_pkg::rsp_t             rsp_q;

	logic                       exec;
	logic                       full;
	logic                       found;
	smpt_pkg::cell_ctrl_t       ctrl;
	logic [smpt_pkg::VAL_W-1:0] taken;

	logic [CAPACITY-1:0]        occ;
	logic [CAPACITY-1:0]        at_count;
	logic [CAPACITY-1:0]        gt;
	logic [CAPACITY-1:0]        le;
	logic [smpt_pkg::VAL_W-1:0] data      [CAPACITY];
	logic [smpt_pkg::VAL_W-1:0] take_part [CAPACITY];

	assign cmd.ready = !busy_q;
	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_q;

	assign exec  = busy_q && (!rsp_valid_q || rsp.ready);
	assign full  = (count_q == CW'(CAPACITY));
	assign found = le[0];

	assign ctrl.insert_en = exec && (op_s1 == smpt_pkg::OP_INSERT) && !full;
	assign ctrl.take_en   = exec && (op_s1 == smpt_pkg::OP_TAKE) && found;
	assign ctrl.value     = value_s1;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [smpt_pkg::VAL_W-1:0] lo_data;
		logic                       lo_gt;
		logic [smpt_pkg::VAL_W-1:0] up_data;
		logic                       up_le;

		assign occ[i]      = (CW'(i) < count_q);
		assign at_count[i] = (CW'(i) == count_q);

		if (i == 0) begin : g_bottom
			assign lo_data = '0;
			assign lo_gt   = 1'b0;
		end else begin : g_lo
			assign lo_data = data[i-1];
			assign lo_gt   = gt[i-1];
		end

		if (i == CAPACITY - 1) begin : g_top
			assign up_data = data[i];
			assign up_le   = 1'b0;
		end else begin : g_up
			assign up_data = data[i+1];
			assign up_le   = le[i+1];
		end

		smpt_cell u_cell (
			.clk       (clk),
			.ctrl      (ctrl),
			.occ       (occ[i]),
			.at_count  (at_count[i]),
			.lo_data   (lo_data),
			.lo_gt     (lo_gt),
			.up_data   (up_data),
			.up_le     (up_le),
			.data      (data[i]),
			.gt        (gt[i]),
			.le        (le[i]),
			.take_part (take_part[i])
		);
	end

	// At most one cell drives a nonzero part.
	always_comb begin
		taken = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			taken = taken | take_part[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.valid && cmd.ready) begin
				busy_q <= 1'b1;
			end else if (exec) begin
				busy_q <= 1'b0;
			end

			if (exec) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end

			if (ctrl.insert_en) begin
				count_q <= count_q + 1'b1;
			end else if (ctrl.take_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			op_s1    <= cmd.data.op;
			value_s1 <= cmd.data.value;
		end
		if (exec) begin
			if (op_s1 == smpt_pkg::OP_INSERT) begin
				rsp_q.status      <= full ? smpt_pkg::ST_FULL : smpt_pkg::ST_INSERTED;
				rsp_q.taken_value <= '0;
			end else begin
				rsp_q.status      <= found ? smpt_pkg::ST_TAKEN : smpt_pkg::ST_NONE;
				rsp_q.taken_value <= taken;
			end
		end
	end

	`SMPT_NEVER(a_count_in_range, count_q > CW'(CAPACITY))
	`SMPT_CHECK(a_take_drops_count, ctrl.take_en |=> count_q == $past(count_q) - 1'b1)
	`SMPT_NEVER(a_zero_unless_taken, rsp_valid_q && rsp_q.status != smpt_pkg::ST_TAKEN && rsp_q.taken_value != '0)
	`SMPT_CHECK(a_full_drop, exec && op_s1 == smpt_pkg::OP_INSERT && full |=> rsp_q.status == smpt_pkg::ST_FULL && $stable(count_q))

endmodule
`default_nettype wire

/* tb/tb_sorted_multiset_predecessor_take_unit.sv */
`timescale 1ns / 100ps
module tb_sorted_multiset_predecessor_take_unit;

	localparam int VAL_W      = smpt_pkg::VAL_W;
	localparam int RAND_ITEMS = 1750;
	localparam int IDLE_LIMIT = 4000;
	localparam int DIR_ROWS   = 25;

	typedef struct packed {
		smpt_pkg::cmd_t beat;
		logic           typed;
		smpt_pkg::rsp_t rsp;
	} dir_row_t;

	logic clk;
	logic arst_n;

	smpt_chan_if #(.T(smpt_pkg::cmd_t)) cmd_ch ();
	smpt_chan_if #(.T(smpt_pkg::rsp_t)) rsp_ch ();

	sorted_multiset_predecessor_take_unit u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch.sink),
		.rsp    (rsp_ch.source)
	);

	// Table entries with typed=1 carry a response readable by inspection.
	dir_row_t dir_rows [0:DIR_ROWS-1] = '{
		'{'{smpt_pkg::OP_TAKE,   32'h0000_0000}, 1'b1, '{smpt_pkg::ST_NONE,     32'h0}},
		'{'{smpt_pkg::OP_TAKE,   32'hFFFF_FFFF}, 1'b1, '{smpt_pkg::ST_NONE,     32'h0}},
		'{'{smpt_pkg::OP_INSERT, 32'h0000_0000}, 1'b1, '{smpt_pkg::ST_INSERTED, 32'h0}},
		'{'{smpt_pkg::OP_INSERT, 32'hFFFF_FFFF}, 1'b1, '{smpt_pkg::ST_INSERTED, 32'h0}},
		'{'{smpt_pkg::OP_INSERT, 32'h0000_0005}, 1'b1, '{smpt_pkg::ST_INSERTED, 32'h0}},
		'{'{smpt_pkg::OP_INSERT, 32'h0000_0005}, 1'b1, '{smpt_pkg::ST_INSERTED, 32'h0}},
		'{'{smpt_pkg::OP_TAKE,   32'h0000_0004}, 1'b0, '{smpt_pkg::ST_INSERTED, 32'h0}},
		'{'{smpt_pkg::OP_TAKE,   32'h0000_0004}, 1'b0, '{smpt_pkg::ST_INSERTED, 32'h0}},
		'{'{smpt_pkg::OP_TAKE,   32'h0000_0005}, 1'b0, '{smpt_pkg::ST_INSERTED, 32'h0}},
		'{'{smpt_pkg::OP_TAKE,   32'h0000_0005}, 1'b0, '{smpt_pkg::ST_INSERTED, 32'h0}},
		'{'{smpt_pkg::OP_TAKE,   32'hFFFF_FFFE}, 1'b0, '{smpt_pkg::ST_INSERTED, 32'h0}},
		'{'{smpt_pkg::OP_TAKE,   32'hFFFF_FFFF}, 1'b1, '{smpt_pkg::ST_TAKEN,    32'hFFFF_FFFF}},
		'{'{smpt_pkg::OP_INSERT, 32'hA5A5_A5A5}, 1'b1, '{smpt_pkg::ST_INSERTED, 32'h0}},
		'{'{smpt_pkg::OP_INSERT, 32'h5A5A_5A5A}, 1'b1, '{smpt_pkg::ST_INSERTED, 32'h0}},
		'{'{smpt_pkg::OP_INSERT, 32'h7FFF_FFFF}, 1'b1, '{smpt_pkg::ST_INSERTED, 32'h0}},
		'{'{smpt_pkg::OP_INSERT, 32'h8000_0000}, 1'b1, '{smpt_pkg::ST_INSERTED, 32'h0}},
		'{'{smpt_pkg::OP_TAKE,   32'h8000_0000}, 1'b0, '{smpt_pkg::ST_INSERTED, 32'h0}},
		'{'{smpt_pkg::OP_TAKE,   32'h7FFF_FFFF}, 1'b0, '{smpt_pkg::ST_INSERTED, 32'h0}},
		'{'{smpt_pkg::OP_TAKE,   32'hA5A5_A5A4}, 1'b0, '{smpt_pkg::ST_INSERTED, 32'h0}},
		'{'{smpt_pkg::OP_TAKE,   32'h0000_0000}, 1'b0, '{smpt_pkg::ST_INSERTED, 32'h0}},
		'{'{smpt_pkg::OP_TAKE,   32'hFFFF_FFFF}, 1'b0, '{smpt_pkg::ST_INSERTED, 32'h0}},
		'{'{smpt_pkg::OP_INSERT, 32'h0000_0001}, 1'b1, '{smpt_pkg::ST_INSERTED, 32'h0}},
		'{'{smpt_pkg::OP_INSERT, 32'h0000_0001}, 1'b1, '{smpt_pkg::ST_INSERTED, 32'h0}},
		'{'{smpt_pkg::OP_TAKE,   32'h0000_0001}, 1'b0, '{smpt_pkg::ST_INSERTED, 32'h0}},
		'{'{smpt_pkg::OP_TAKE,   32'h0000_0001}, 1'b0, '{smpt_pkg::ST_INSERTED, 32'h0}}
	};

	logic [VAL_W-1:0] held_vals [$];
	smpt_pkg::rsp_t   pending_rsp [$];

	int unsigned err_cnt;
	int unsigned idle_cycles;
	int unsigned burst_left;
	int unsigned n_inserted;
	int unsigned n_taken;
	int unsigned n_none;
	int unsigned n_full;
	int unsigned peak_held;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Apply one command to the shadow multiset and return its response.
	function automatic smpt_pkg::rsp_t predict_cmd(input smpt_pkg::cmd_t c);
		smpt_pkg::rsp_t r;
		int             pos;
		r.status      = smpt_pkg::ST_INSERTED;
		r.taken_value = '0;
		pos           = held_vals.size();
		if (c.op == smpt_pkg::OP_INSERT) begin
			if (held_vals.size() >= smpt_pkg::CAPACITY) begin
				r.status = smpt_pkg::ST_FULL;
				n_full++;
			end else begin
				// land after any equal copies
				while (pos > 0 && held_vals[pos-1] > c.value)
					pos--;
				held_vals.insert(pos, c.value);
				n_inserted++;
				if (held_vals.size() > peak_held)
					peak_held = held_vals.size();
			end
		end else begin
			while (pos > 0 && held_vals[pos-1] > c.value)
				pos--;
			if (pos == 0) begin
				r.status = smpt_pkg::ST_NONE;
				n_none++;
			end else begin
				r.status      = smpt_pkg::ST_TAKEN;
				r.taken_value = held_vals[pos-1];
				held_vals.delete(pos-1);
				n_taken++;
			end
		end
		return r;
	endfunction

	function automatic logic [VAL_W-1:0] pick_value();
		int unsigned sel;
		int unsigned idx;
		sel = $urandom_range(0, 9);
		case (sel)
		4, 5: begin
			return VAL_W'($urandom_range(0, 15));
		end
		6: begin
			return '0;
		end
		7: begin
			return '1;
		end
		8, 9: begin
			if (held_vals.size() == 0)
				return $urandom;
			// land on or next to a held value
			idx = $urandom_range(0, held_vals.size() - 1);
			return held_vals[idx] + VAL_W'($urandom_range(0, 2)) - 1;
		end
		default: begin
			return $urandom;
		end
		endcase
	endfunction

	task automatic send_cmd(input smpt_pkg::cmd_t c, input logic typed,
		input smpt_pkg::rsp_t typed_rsp);
		int unsigned    gap;
		smpt_pkg::rsp_t pred;
		@(negedge clk);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 48);
			gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap != 0) begin
				cmd_ch.valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		cmd_ch.valid <= 1'b1;
		cmd_ch.data  <= c;
		@(posedge clk);
		while (!cmd_ch.ready)
			@(posedge clk);
		pred = predict_cmd(c);
		pending_rsp.insert(pending_rsp.size(), typed ? typed_rsp : pred);
	endtask

	// Receiver stall pattern: runs of always-ready, coin flips, mostly-ready
	// and long stalls.
	initial begin
		int unsigned pat_mode;
		int unsigned pat_left;
		pat_mode     = 0;
		pat_left     = 0;
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (pat_left == 0) begin
				pat_mode = $urandom_range(0, 3);
				pat_left = $urandom_range(8, 64);
			end
			pat_left--;
			case (pat_mode)
			0: begin
				rsp_ch.ready <= 1'b1;
			end
			1: begin
				rsp_ch.ready <= 1'($urandom_range(0, 1));
			end
			2: begin
				rsp_ch.ready <= ($urandom_range(0, 7) != 0);
			end
			default: begin
				rsp_ch.ready <= (pat_left % 10 == 0);
			end
			endcase
		end
	end

	always @(posedge clk) begin
		smpt_pkg::rsp_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_rsp.size() == 0) begin
				err_cnt++;
				if (err_cnt <= 10)
					$display("%0t: response beat with nothing pending: status %0d value %h",
						$realtime, rsp_ch.data.status, rsp_ch.data.taken_value);
			end else begin
				want = pending_rsp[0];
				pending_rsp.delete(0);
				if (rsp_ch.data.status !== want.status ||
				    rsp_ch.data.taken_value !== want.taken_value) begin
					err_cnt++;
					if (err_cnt <= 10)
						$display("%0t: status exp %0d got %0d, taken_value exp %h got %h",
							$realtime, want.status, rsp_ch.data.status,
							want.taken_value, rsp_ch.data.taken_value);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
				idle_cycles <= 0;
			end else begin
				idle_cycles <= idle_cycles + 1;
				if (idle_cycles >= IDLE_LIMIT) begin
					$display("tb_sorted_multiset_predecessor_take_unit: errors");
					$finish;
				end
			end
		end
	end

	initial begin
		smpt_pkg::cmd_t c;
		int unsigned    random_sent;
		int unsigned    round_mode;
		int unsigned    round_len;
		int unsigned    take_pct;
		int             extra;
		arst_n       = 1'b0;
		cmd_ch.valid = 1'b0;
		cmd_ch.data  = '0;
		err_cnt      = 0;
		idle_cycles  = 0;
		burst_left   = 0;
		n_inserted   = 0;
		n_taken      = 0;
		n_none       = 0;
		n_full       = 0;
		peak_held    = 0;
		random_sent  = 0;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[i])
			send_cmd(dir_rows[i].beat, dir_rows[i].typed, dir_rows[i].rsp);

		// fill to capacity, then push a few inserts that must be dropped
		while (held_vals.size() < smpt_pkg::CAPACITY) begin
			c.op    = smpt_pkg::OP_INSERT;
			c.value = pick_value();
			send_cmd(c, 1'b0, '0);
			random_sent++;
		end
		for (extra = 0; extra < 6; extra++) begin
			c.op    = smpt_pkg::OP_INSERT;
			c.value = pick_value();
			send_cmd(c, 1'b0, '0);
			random_sent++;
		end

		// drain to empty, then take from the empty store
		while (held_vals.size() != 0) begin
			c.op    = smpt_pkg::OP_TAKE;
			c.value = ($urandom_range(0, 3) != 0) ? '1 : pick_value();
			send_cmd(c, 1'b0, '0);
			random_sent++;
		end
		for (extra = 0; extra < 3; extra++) begin
			c.op    = smpt_pkg::OP_TAKE;
			c.value = pick_value();
			send_cmd(c, 1'b0, '0);
			random_sent++;
		end

		// rounds leaning toward growth, shrinkage or balance
		while (random_sent < RAND_ITEMS) begin
			round_mode = $urandom_range(0, 2);
			round_len  = $urandom_range(20, 200);
			take_pct   = (round_mode == 0) ? 15 : (round_mode == 1) ? 85 : 50;
			repeat (round_len) begin
				c.op    = ($urandom_range(0, 99) < take_pct) ?
					smpt_pkg::OP_TAKE : smpt_pkg::OP_INSERT;
				c.value = pick_value();
				if (round_mode == 1 && c.op == smpt_pkg::OP_TAKE &&
				    $urandom_range(0, 2) == 0)
					c.value = '1;
				send_cmd(c, 1'b0, '0);
				random_sent++;
			end
		end

		@(negedge clk);
		cmd_ch.valid <= 1'b0;
		while (pending_rsp.size() != 0)
			@(posedge clk);
		// hold a little longer to catch stray beats
		repeat (12) @(posedge clk);

		$display("ran %0d commands: %0d inserts kept, %0d dropped on full store",
			DIR_ROWS + random_sent, n_inserted, n_full);
		$display("%0d takes hit, %0d found nothing at or below the limit, peak occupancy %0d",
			n_taken, n_none, peak_held);
		if (err_cnt == 0) begin
			$display("tb_sorted_multiset_predecessor_take_unit: clean");
		end else begin
			$display("%0d mismatches", err_cnt);
			$display("tb_sorted_multiset_predecessor_take_unit: errors");
		end
		$finish;
	end

endmodule
